/* design/triangle_lda_distribution_coefficients_core_assert.svh */
// assertion macros for the triangle lda coefficient core
// expects clk and rst in the scope of use
`ifndef TRIANGLE_LDA_DISTRIBUTION_COEFFICIENTS_CORE_ASSERT_SVH
`define TRIANGLE_LDA_DISTRIBUTION_COEFFICIENTS_CORE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define TDC_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle, checked through reset
`define TDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* design/tdc_pkg.sv */
// shared types and constants for the triangle lda coefficient core
// no dependencies
`default_nettype none
package tdc_pkg;
  localparam int CoordW  = 32;
  localparam int AreaW   = 31;
  localparam int WeightW = 17;
  localparam int PosW    = 51;
  localparam int SumW    = 53;
  localparam int CfgIdxW = 8;

  typedef logic signed [CoordW-1:0]  coord_t;
  typedef logic        [AreaW-1:0]   area_t;
  typedef logic        [WeightW-1:0] weight_t;
  typedef logic        [PosW-1:0]    pos_t;
  typedef logic        [SumW-1:0]    sum_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_METHOD_SELECT = 8'd0,
    REG_TIME_STEP     = 8'd1
  } cfg_reg_t;

  localparam logic [31:0] TimeStepReset = 32'd655;
endpackage
`default_nettype wire

/* design/tdc_if.sv */
// channel interfaces: triangle input, coefficient result, register write
// depends on tdc_pkg
`default_nettype none
interface tdc_in_if;
  import tdc_pkg::*;
  logic   valid;
  logic   ready;
  coord_t vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y, vertex_c_x, vertex_c_y;
  coord_t flow_x, flow_y;
  area_t  cell_area;
  modport source (output valid, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
                  vertex_c_x, vertex_c_y, flow_x, flow_y, cell_area, input ready);
  modport sink (input valid, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
                vertex_c_x, vertex_c_y, flow_x, flow_y, cell_area, output ready);
endinterface

interface tdc_out_if;
  import tdc_pkg::*;
  logic    valid;
  logic    ready;
  coord_t  upwind_a, upwind_b, upwind_c;
  weight_t weight_a, weight_b, weight_c;
  logic    zero_denominator;
  modport source (output valid, upwind_a, upwind_b, upwind_c, weight_a, weight_b,
                  weight_c, zero_denominator, input ready);
  modport sink (input valid, upwind_a, upwind_b, upwind_c, weight_a, weight_b,
                weight_c, zero_denominator, output ready);
endinterface

interface tdc_cfg_if;
  import tdc_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [31:0]        data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* design/tdc_lane.sv */
// one vertex lane: edge normal, upwind value k and positive part, 5 stages
// depends on tdc_pkg
`default_nettype none
module tdc_lane (
  input  wire             clk,
  input  wire             en,
  input  tdc_pkg::coord_t vy_next,
  input  tdc_pkg::coord_t vy_far,
  input  tdc_pkg::coord_t vx_next,
  input  tdc_pkg::coord_t vx_far,
  input  tdc_pkg::coord_t flow_x,
  input  tdc_pkg::coord_t flow_y,
  input  tdc_pkg::area_t  area,
  input  wire             method,
  input  wire [31:0]      dt,
  output tdc_pkg::coord_t k,
  output tdc_pkg::pos_t   pos
);
  import tdc_pkg::*;

  logic signed [32:0] nx, ny;
  coord_t             fx1, fy1;
  area_t              area1, area2, area3, area4;
  logic signed [64:0] p1, p2;
  coord_t             k3, k4;
  logic signed [64:0] t4;
  coord_t             k5;
  pos_t               pos5;

  logic signed [65:0] s_sum;
  logic signed [48:0] s_shr;
  coord_t             k_sat;
  logic signed [47:0] q;
  logic signed [51:0] v;

  always_comb begin
    s_sum = 66'(p1) + 66'(p2);
    s_shr = 49'(s_sum >>> 17);
    if (s_shr > 49'sh0_7FFF_FFFF) begin
      k_sat = 32'sh7FFF_FFFF;
    end else if (s_shr < -49'sh0_8000_0000) begin
      k_sat = -32'sh8000_0000;
    end else begin
      k_sat = 32'(s_shr);
    end
    q = 48'(t4 >>> 17);
    if (method) begin
      v = (52'(q) <<< 1) + 52'(q) + $signed({21'd0, area4});
    end else begin
      v = 52'(k4);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx    <= 33'(vy_next) - 33'(vy_far);
      ny    <= 33'(vx_far) - 33'(vx_next);
      fx1   <= flow_x;
      fy1   <= flow_y;
      area1 <= area;
      p1    <= 65'(fx1) * 65'(nx);
      p2    <= 65'(fy1) * 65'(ny);
      area2 <= area1;
      k3    <= k_sat;
      area3 <= area2;
      t4    <= $signed({33'd0, dt}) * 65'(k3);
      k4    <= k3;
      area4 <= area3;
      k5    <= k4;
      pos5  <= (v > 52'sd0) ? PosW'(v) : '0;
    end
  end

  assign k   = k5;
  assign pos = pos5;
endmodule
`default_nettype wire

/* design/tdc_div.sv */
// pipelined restoring divider, floor(pos * 2^16 / sum), one quotient bit a stage
// depends on tdc_pkg
`default_nettype none
module tdc_div #(
  parameter int TAG_W = 32
) (
  input  wire               clk,
  input  wire               en,
  input  tdc_pkg::pos_t     pos,
  input  tdc_pkg::sum_t     sum,
  input  wire [TAG_W-1:0]   tag_in,
  output tdc_pkg::weight_t  quo,
  output logic [TAG_W-1:0]  tag_out
);
  import tdc_pkg::*;

  localparam int RemW = SumW + 1;

  logic [RemW-1:0]    rem   [WeightW];
  logic [SumW-1:0]    dvs   [WeightW];
  logic [WeightW-1:0] qacc  [WeightW];
  logic [TAG_W-1:0]   tag   [WeightW];

  logic            ge0;
  logic [RemW-1:0] pos_ext;

  assign pos_ext = RemW'(pos);
  assign ge0     = pos_ext >= RemW'(sum);

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= ge0 ? pos_ext - RemW'(sum) : pos_ext;
      dvs[0]  <= sum;
      qacc[0] <= WeightW'(ge0);
      tag[0]  <= tag_in;
    end
  end

  for (genvar j = 1; j < WeightW; j++) begin : g_stage
    logic [RemW-1:0] sh;
    logic            ge;
    assign sh = rem[j-1] << 1;
    assign ge = sh >= RemW'(dvs[j-1]);
    always_ff @(posedge clk) begin
      if (en) begin
        rem[j]  <= ge ? sh - RemW'(dvs[j-1]) : sh;
        dvs[j]  <= dvs[j-1];
        qacc[j] <= {qacc[j-1][WeightW-2:0], ge};
        tag[j]  <= tag[j-1];
      end
    end
  end

  assign quo     = qacc[WeightW-1];
  assign tag_out = tag[WeightW-1];
endmodule
`default_nettype wire

/* design/triangle_lda_distribution_coefficients_core.sv */
// pipeline from input transfer to result: 5 lane stages, 1 sum stage and
// a 17-stage divider per vertex; one triangle per cycle while not stalled
// the whole pipeline stalls only when the result register is full and not taken
// rst is synchronous: clears the valid pipeline, method_select to 0, time_step to 655
// depends on tdc_pkg, tdc_if, tdc_lane, tdc_div and the assertion header
`default_nettype none
module triangle_lda_distribution_coefficients_core (
  input wire        clk,
  input wire        rst,
  tdc_in_if.sink    tri_in,
  tdc_out_if.source coef_out,
  tdc_cfg_if.sink   cfg
);
  import tdc_pkg::*;
  `include "triangle_lda_distribution_coefficients_core_assert.svh"

  localparam int LaneLat = 5;
  localparam int Depth   = LaneLat + 1 + WeightW;

  logic        method_select;
  logic [31:0] time_step;
  logic [Depth-1:0] vld;
  logic        en;

  assign en           = !vld[Depth-1] || coef_out.ready;
  assign tri_in.ready = en;
  assign cfg.ready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      method_select <= 1'b0;
      time_step     <= TimeStepReset;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_METHOD_SELECT: method_select <= cfg.data[0];
        REG_TIME_STEP:     time_step     <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Depth-2:0], tri_in.valid};
    end
  end

  coord_t k_a, k_b, k_c;
  pos_t   p_a, p_b, p_c;

  tdc_lane u_lane_a (.clk, .en, .vy_next(tri_in.vertex_b_y), .vy_far(tri_in.vertex_c_y),
    .vx_next(tri_in.vertex_b_x), .vx_far(tri_in.vertex_c_x), .flow_x(tri_in.flow_x),
    .flow_y(tri_in.flow_y), .area(tri_in.cell_area), .method(method_select),
    .dt(time_step), .k(k_a), .pos(p_a));
  tdc_lane u_lane_b (.clk, .en, .vy_next(tri_in.vertex_c_y), .vy_far(tri_in.vertex_a_y),
    .vx_next(tri_in.vertex_c_x), .vx_far(tri_in.vertex_a_x), .flow_x(tri_in.flow_x),
    .flow_y(tri_in.flow_y), .area(tri_in.cell_area), .method(method_select),
    .dt(time_step), .k(k_b), .pos(p_b));
  tdc_lane u_lane_c (.clk, .en, .vy_next(tri_in.vertex_a_y), .vy_far(tri_in.vertex_b_y),
    .vx_next(tri_in.vertex_a_x), .vx_far(tri_in.vertex_b_x), .flow_x(tri_in.flow_x),
    .flow_y(tri_in.flow_y), .area(tri_in.cell_area), .method(method_select),
    .dt(time_step), .k(k_c), .pos(p_c));

  // merge: denominator of the three positive parts
  sum_t   sum6;
  logic   zero6;
  pos_t   pa6, pb6, pc6;
  coord_t ka6, kb6, kc6;

  always_ff @(posedge clk) begin
    if (en) begin
      sum6  <= SumW'(p_a) + SumW'(p_b) + SumW'(p_c);
      zero6 <= (p_a == '0) && (p_b == '0) && (p_c == '0);
      pa6   <= p_a;
      pb6   <= p_b;
      pc6   <= p_c;
      ka6   <= k_a;
      kb6   <= k_b;
      kc6   <= k_c;
    end
  end

  weight_t     q_a, q_b, q_c;
  logic [32:0] tag_a;
  coord_t      tag_b, tag_c;

  tdc_div #(.TAG_W(33)) u_div_a (.clk, .en, .pos(pa6), .sum(sum6),
    .tag_in({zero6, ka6}), .quo(q_a), .tag_out(tag_a));
  tdc_div #(.TAG_W(32)) u_div_b (.clk, .en, .pos(pb6), .sum(sum6),
    .tag_in(kb6), .quo(q_b), .tag_out(tag_b));
  tdc_div #(.TAG_W(32)) u_div_c (.clk, .en, .pos(pc6), .sum(sum6),
    .tag_in(kc6), .quo(q_c), .tag_out(tag_c));

  assign coef_out.valid            = vld[Depth-1];
  assign coef_out.zero_denominator = tag_a[32];
  assign coef_out.upwind_a         = tag_a[31:0];
  assign coef_out.upwind_b         = tag_b;
  assign coef_out.upwind_c         = tag_c;
  assign coef_out.weight_a         = tag_a[32] ? '0 : q_a;
  assign coef_out.weight_b         = tag_a[32] ? '0 : q_b;
  assign coef_out.weight_c         = tag_a[32] ? '0 : q_c;

  `TDC_ASSERT_IMPLY(a_zero_weights, coef_out.valid && coef_out.zero_denominator,
    (coef_out.weight_a | coef_out.weight_b | coef_out.weight_c) == '0,
    "weights nonzero with zero denominator")
  `TDC_ASSERT_IMPLY(a_weight_total, coef_out.valid,
    19'(coef_out.weight_a) + 19'(coef_out.weight_b) + 19'(coef_out.weight_c) <= 19'd65536,
    "weights exceed one")
  `TDC_ASSERT_NEXT(a_reset_empty, rst, !coef_out.valid, "result valid after reset")
endmodule
`default_nettype wire

/* tb/tb_triangle_lda_distribution_coefficients_core.sv */
// testbench for the triangle lda coefficient core: directed and random triangles,
// scoreboard prediction of upwind values and weights; depends on tdc_pkg, tdc_if and the core
`timescale 1ns / 100ps
`default_nettype none

class lda_coef_scoreboard;
  typedef struct packed {
    logic [31:0] ka, kb, kc;
    logic [16:0] wa, wb, wc;
    logic        zd;
  } coef_t;

  coef_t expected_coefs[$];
  bit          mode_space_time;
  logic [31:0] dt;
  int          mismatches;
  int          checked;

  function new();
    mode_space_time = 0;
    dt = tdc_pkg::TimeStepReset;
    mismatches = 0;
    checked = 0;
  endfunction

  // floor((fx*nx + fy*ny) / 2^17) taken from the exact sum, then saturated
  function automatic longint upwind(longint fx, longint fy, longint nx, longint ny);
    logic signed [127:0] s;
    logic signed [127:0] q;
    s = 128'(fx) * 128'(nx) + 128'(fy) * 128'(ny);
    q = s >>> 17;
    if (q > 128'sd2147483647) return 64'sd2147483647;
    if (q < -128'sd2147483648) return -64'sd2147483648;
    return longint'(q);
  endfunction

  function void note_triangle(logic [31:0] v[6], logic [31:0] fxr, logic [31:0] fyr,
                              logic [30:0] area);
    longint vx[3], vy[3], k[3], fx, fy, val, q;
    logic signed [127:0] prod;
    logic [63:0] pos[3], sum;
    coef_t c;
    fx = longint'($signed(fxr));
    fy = longint'($signed(fyr));
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      vx[i] = longint'($signed(v[2*i]));
      vy[i] = longint'($signed(v[2*i+1]));
    end
    for (int i = 0; i < 3; i++)
      k[i] = upwind(fx, fy, vy[(i+1)%3] - vy[(i+2)%3], vx[(i+2)%3] - vx[(i+1)%3]);
    for (int i = 0; i < 3; i++) begin
      if (!mode_space_time) val = k[i];
      else begin
        prod = 128'($signed({1'b0, dt})) * 128'(k[i]);
        q = longint'(prod >>> 17);
        val = 3 * q + longint'({33'd0, area});
      end
      pos[i] = val > 0 ? 64'(val) : 64'd0;
      sum += pos[i];
    end
    c.ka = k[0][31:0];
    c.kb = k[1][31:0];
    c.kc = k[2][31:0];
    c.zd = (sum == 0);
    if (sum == 0) begin
      c.wa = 0; c.wb = 0; c.wc = 0;
    end else begin
      c.wa = 17'((pos[0] * 64'd65536) / sum);
      c.wb = 17'((pos[1] * 64'd65536) / sum);
      c.wc = 17'((pos[2] * 64'd65536) / sum);
    end
    expected_coefs.push_back(c);
  endfunction

  function void check_result(coef_t got);
    coef_t exp_c;
    checked++;
    if (expected_coefs.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h", got);
      return;
    end
    exp_c = expected_coefs.pop_front();
    if (got !== exp_c) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: exp k %h %h %h w %h %h %h z %b / got k %h %h %h w %h %h %h z %b",
                 exp_c.ka, exp_c.kb, exp_c.kc, exp_c.wa, exp_c.wb, exp_c.wc, exp_c.zd,
                 got.ka, got.kb, got.kc, got.wa, got.wb, got.wc, got.zd);
    end
  endfunction
endclass

module tb_triangle_lda_distribution_coefficients_core;
  import tdc_pkg::*;

  localparam int Latency = 23;
  localparam longint CycleLimit = 400000;

  logic clk;
  logic rst;
  tdc_in_if  tri_in ();
  tdc_out_if coef_out ();
  tdc_cfg_if cfg ();

  triangle_lda_distribution_coefficients_core DUT (
    .clk(clk), .rst(rst), .tri_in(tri_in), .coef_out(coef_out), .cfg(cfg)
  );

  lda_coef_scoreboard board;
  int     send_idle_pct, recv_stall_pct;
  longint cycles;
  int     triangles_sent;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver: random stall, check on every transfer
  always @(posedge clk) begin
    if (!rst && coef_out.valid && coef_out.ready)
      board.check_result({coef_out.upwind_a, coef_out.upwind_b, coef_out.upwind_c,
                          coef_out.weight_a, coef_out.weight_b, coef_out.weight_c,
                          coef_out.zero_denominator});
    coef_out.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic write_reg(cfg_reg_t idx, logic [31:0] value);
    cfg.valid <= 1;
    cfg.index <= idx;
    cfg.data  <= value;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 0;
    if (idx == REG_METHOD_SELECT) board.mode_space_time = value[0];
    else board.dt = value;
    // wait idle with valid low so a following write starts in a new time step
    @(posedge clk);
  endtask

  task automatic send_triangle(logic [31:0] v[6], logic [31:0] fx, logic [31:0] fy,
                               logic [30:0] area);
    while ($urandom_range(99) < send_idle_pct) begin
      tri_in.valid <= 0;
      @(posedge clk);
    end
    tri_in.valid <= 1;
    {tri_in.vertex_a_x, tri_in.vertex_a_y, tri_in.vertex_b_x} <= {v[0], v[1], v[2]};
    {tri_in.vertex_b_y, tri_in.vertex_c_x, tri_in.vertex_c_y} <= {v[3], v[4], v[5]};
    tri_in.flow_x <= fx;
    tri_in.flow_y <= fy;
    tri_in.cell_area <= area;
    do @(posedge clk); while (!tri_in.ready);
    board.note_triangle(v, fx, fy, area);
    triangles_sent++;
  endtask

  task automatic drain();
    tri_in.valid <= 0;
    while (board.expected_coefs.size() != 0) @(posedge clk);
    repeat (Latency + 5) @(posedge clk);
  endtask

  // mostly small well-shaped triangles, some full-range noise
  task automatic random_triangle();
    logic [31:0] v[6];
    logic [31:0] fx, fy;
    logic [30:0] area;
    int shape;
    shape = $urandom_range(9);
    for (int i = 0; i < 6; i++)
      v[i] = (shape < 7) ? 32'($signed($urandom_range(20 << 16)) - (10 << 16)) : $urandom;
    fx = (shape < 7) ? 32'($signed($urandom_range(8 << 16)) - (4 << 16)) : $urandom;
    fy = (shape < 7) ? 32'($signed($urandom_range(8 << 16)) - (4 << 16)) : $urandom;
    area = (shape < 5) ? 31'($urandom_range(50 << 16)) : 31'($urandom);
    send_triangle(v, fx, fy, area);
  endtask

  task automatic directed_set();
    logic [31:0] v[6];
    v = '{32'h0, 32'h0, 32'h10000, 32'h0, 32'h0, 32'h10000};
    send_triangle(v, 32'h10000, 32'h8000, 31'h8000);        // ccw unit triangle
    v = '{32'h0, 32'h0, 32'h0, 32'h10000, 32'h10000, 32'h0};
    send_triangle(v, 32'h10000, 32'h8000, 31'h8000);        // clockwise, k negated
    send_triangle(v, 32'h0, 32'h0, 31'h0);                  // zero flow, zero sum
    send_triangle(v, 32'h0, 32'h0, 31'h7fffffff);
    v = '{32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
          32'h80000000, 32'h80000000};
    send_triangle(v, 32'h80000000, 32'h80000000, 31'h7fffffff); // k saturates high
    send_triangle(v, 32'h7fffffff, 32'h7fffffff, 31'h0);        // k saturates low
    send_triangle(v, 32'h7fffffff, 32'h80000000, 31'h1);
    v = '{32'hffffffff, 32'hffffffff, 32'h1, 32'h1, 32'hffffffff, 32'h1};
    send_triangle(v, 32'hffffffff, 32'h1, 31'h3);           // odd products, floor
    send_triangle(v, 32'h1, 32'hffffffff, 31'h0);
    v = '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0};
    send_triangle(v, 32'hffffffff, 32'hffffffff, 31'h7fffffff); // degenerate
    v = '{32'h0, 32'h0, 32'h20000, 32'h0, 32'h10000, 32'h30000};
    send_triangle(v, 32'h0, 32'h10000, 31'h30000);          // one vertex upwind
    send_triangle(v, 32'h0, 32'hffff0000, 31'h30000);
  endtask

  initial begin
    logic [31:0] steps[5];
    board = new();
    cycles = 0;
    triangles_sent = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst = 1;
    tri_in.valid = 0;
    {tri_in.vertex_a_x, tri_in.vertex_a_y, tri_in.vertex_b_x, tri_in.vertex_b_y} = '0;
    {tri_in.vertex_c_x, tri_in.vertex_c_y, tri_in.flow_x, tri_in.flow_y} = '0;
    tri_in.cell_area = '0;
    cfg.valid = 0;
    cfg.index = REG_METHOD_SELECT;
    cfg.data = 0;
    coef_out.ready = 0;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    steps = '{32'd655, 32'h0, 32'hffffffff, 32'h10000, 32'h1};
    directed_set();
    drain();
    for (int phase = 0; phase < 10; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      write_reg(REG_METHOD_SELECT, 32'(phase % 2));
      write_reg(REG_TIME_STEP, (phase < 5) ? steps[phase] : $urandom);
      if (phase == 1 || phase == 2) directed_set();
      for (int n = 0; n < 165; n++) random_triangle();
      drain();
    end

    $display("%0d triangles in LDA and space-time modes, %0d results checked, %0d mismatches",
             triangles_sent, board.checked, board.mismatches);
    if (board.mismatches == 0 && board.expected_coefs.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end
endmodule

`default_nettype wire
